// ===== hw/rtl/round_robin_matching_selector_assert.svh =====
// assertion macros used by the checker module
// no dependencies; take in with a plain include

`ifndef ROUND_ROBIN_MATCHING_SELECTOR_ASSERT_SVH
`define ROUND_ROBIN_MATCHING_SELECTOR_ASSERT_SVH

// same-cycle implication, idle while reset is asserted
`define RRMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rrms assertion failed");

// next-cycle implication, idle while reset is asserted
`define RRMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rrms assertion failed");

`endif

// ===== hw/rtl/rrms_pkg.sv =====
// shared types, constants and helpers of the round-robin matching selector
// no dependencies

package rrms_pkg;

    // table geometry
    localparam int NUM_ENTRIES = 32;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);

    // request field widths
    localparam int ENTRY_IDX_W = 5;
    localparam int TYPE_W      = 16;
    localparam int SCHEME_W    = 4;

    // compare width that holds both a request index and the table size
    localparam int CMP_W = ((IDX_W > ENTRY_IDX_W) ? IDX_W : ENTRY_IDX_W) + 1;

    // request kinds
    localparam logic KIND_SELECT = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic resolve;
    } ctrl_cmd_t;

    // index of the lowest set bit, zero when none is set
    function automatic logic [IDX_W-1:0] lowest_one(input logic [NUM_ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/rrms_ctrl.sv =====
// controller of the round-robin matching selector: idle / scan sequencing
// depends on rrms_pkg

module rrms_ctrl
    import rrms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // state and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.resolve = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.resolve = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

// ===== hw/rtl/rrms_datapath.sv =====
// datapath of the round-robin matching selector: entry table, parallel
// match, rotating priority pick and start pointer; depends on rrms_pkg

module rrms_datapath
    import rrms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    input  logic                   kind,
    input  logic [ENTRY_IDX_W-1:0] entry_index,
    input  logic                   entry_used,
    input  logic                   entry_active,
    input  logic                   entry_connected,
    input  logic [TYPE_W-1:0]      type_code,
    input  logic [SCHEME_W-1:0]    scheme_code,
    output logic                   found,
    output logic [ENTRY_IDX_W-1:0] selected_index
);

    // entry table
    logic [2:0]             flags_reg  [NUM_ENTRIES];
    logic [TYPE_W-1:0]      type_reg   [NUM_ENTRIES];
    logic [SCHEME_W-1:0]    scheme_reg [NUM_ENTRIES];

    logic [IDX_W-1:0]       ptr_reg;
    logic [IDX_W-1:0]       ptr_next;
    logic [NUM_ENTRIES-1:0] match_reg;
    logic [NUM_ENTRIES-1:0] match_next;
    logic                   is_sel_reg;
    logic                   found_reg;
    logic                   found_next;
    logic [ENTRY_IDX_W-1:0] index_reg;
    logic [ENTRY_IDX_W-1:0] index_next;

    logic [CMP_W-1:0]       wr_idx_ext;
    logic                   wr_ok;
    logic [IDX_W-1:0]       wr_row;
    logic [NUM_ENTRIES-1:0] ge_mask;
    logic [NUM_ENTRIES-1:0] upper_hits;
    logic [IDX_W-1:0]       pick;
    logic                   any_hit;

    // write decode, out-of-range rows are dropped
    assign wr_idx_ext = CMP_W'(entry_index);
    assign wr_ok      = (wr_idx_ext < CMP_W'(NUM_ENTRIES));
    assign wr_row     = wr_idx_ext[IDX_W-1:0];

    // flags cleared at reset, so type and scheme need no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ENTRIES; i++)
            begin
                flags_reg[i] <= 3'b000;
            end
        end
        else if (cmd.capture && (kind == KIND_WRITE) && wr_ok)
        begin
            flags_reg[wr_row] <= {entry_connected, entry_active, entry_used};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && (kind == KIND_WRITE) && wr_ok)
        begin
            type_reg[wr_row]   <= type_code;
            scheme_reg[wr_row] <= scheme_code;
        end
    end

    // parallel compare of every used, active and connected entry against the wanted type and scheme
    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            match_next[i] = (flags_reg[i] == 3'b111) &&
                            (type_reg[i] == type_code) &&
                            (scheme_reg[i] == scheme_code);
        end
    end

    // rotating priority pick: first hit at or above the pointer, else wrap
    always_comb
    begin
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            ge_mask[i] = (IDX_W'(i) >= ptr_reg);
        end
        upper_hits = match_reg & ge_mask;
        any_hit    = |match_reg;
        if (|upper_hits)
        begin
            pick = lowest_one(upper_hits);
        end
        else
        begin
            pick = lowest_one(match_reg);
        end
    end

    // result and pointer update
    always_comb
    begin
        found_next = 1'b0;
        index_next = '0;
        ptr_next   = ptr_reg;
        if (is_sel_reg && any_hit)
        begin
            found_next = 1'b1;
            index_next = ENTRY_IDX_W'(pick);
            if (pick == IDX_W'(NUM_ENTRIES - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = pick + 1'b1;
            end
        end
    end

    // capture and resolve registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            match_reg  <= '0;
            is_sel_reg <= 1'b0;
            found_reg  <= 1'b0;
            index_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                match_reg  <= match_next;
                is_sel_reg <= (kind == KIND_SELECT);
            end
            if (cmd.resolve)
            begin
                ptr_reg   <= ptr_next;
                found_reg <= found_next;
                index_reg <= index_next;
            end
        end
    end

    assign found          = found_reg;
    assign selected_index = index_reg;

endmodule

// ===== hw/rtl/round_robin_matching_selector.sv =====
// channel   | handshake        | fields
// request   | start, busy      | kind, entry_index, entry_used, entry_active,
//           |                  | entry_connected, type_code, scheme_code
// result    | done (strobe)    | found, selected_index
//
// a request is taken at an edge with start high and busy low; busy is high
// for the one scan cycle after, and the result strobe follows in the next
// cycle, during which busy is low again and a new request may be taken
// the match vector is registered before the rotating priority encoder; rst_n
// clears the entry flags and the start pointer
// the result strobe is shown for one cycle only and cannot be held off
// depends on rrms_pkg, rrms_ctrl, rrms_datapath

module round_robin_matching_selector
    import rrms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   kind,
    input  logic [ENTRY_IDX_W-1:0] entry_index,
    input  logic                   entry_used,
    input  logic                   entry_active,
    input  logic                   entry_connected,
    input  logic [TYPE_W-1:0]      type_code,
    input  logic [SCHEME_W-1:0]    scheme_code,
    output logic                   done,
    output logic                   found,
    output logic [ENTRY_IDX_W-1:0] selected_index
);

    ctrl_cmd_t cmd;

    // sequencing
    rrms_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // table, match and pick
    rrms_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (kind),
        .entry_index     (entry_index),
        .entry_used      (entry_used),
        .entry_active    (entry_active),
        .entry_connected (entry_connected),
        .type_code       (type_code),
        .scheme_code     (scheme_code),
        .found           (found),
        .selected_index  (selected_index)
    );

endmodule

// ===== hw/rtl/rrms_checker.sv =====
// port-level checks of the round-robin matching selector, bound to the top
// depends on round_robin_matching_selector_assert.svh

`include "round_robin_matching_selector_assert.svh"

module rrms_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       found,
    input logic [4:0] selected_index
);

    // an accepted request turns busy on in the next cycle
    `RRMS_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // the scan lasts exactly one cycle
    `RRMS_ASSERT_NEXT(a_busy_one_cycle, clk, rst_n, busy, !busy && done)

    // a result only follows a scan cycle
    `RRMS_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, $past(busy))

    // nothing found reports index zero
    `RRMS_ASSERT_SAME(a_miss_index_zero, clk, rst_n, done && !found, selected_index == 5'd0)

endmodule

bind round_robin_matching_selector rrms_checker u_rrms_checker (.*);
